[design/cri_pkg.sv]
// ----------------------------------------------------------------------------
// cri_pkg: shared types and constants of the contour raster interpolator
// Field widths, register indexes and reset values, payload structs.
// ----------------------------------------------------------------------------
package cri_pkg;

  localparam int ELEV_W     = 32;
  localparam int IDX_W      = 12;
  localparam int GRID_W     = 7;
  localparam int STEP_W     = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLUMNS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NODATA_VALUE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_X       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_Y       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_DIAG    = 3'd5;

  localparam logic [GRID_W-1:0] RST_GRID      = 7'd64;
  localparam logic [ELEV_W-1:0] RST_NODATA    = 32'hFFD8_F100; // -9999.0 in Q23.8
  localparam logic [STEP_W-1:0] RST_STEP_AXIS = 24'd256;
  localparam logic [STEP_W-1:0] RST_STEP_DIAG = 24'd362;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    op_e                      operation;
    logic signed [ELEV_W-1:0] elevation;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEV_W-1:0] surface_value;
    logic [IDX_W-1:0]         cell_index;
    logic                     last_cell;
  } out_item_t;

  typedef struct packed {
    logic [GRID_W-1:0] grid_columns;
    logic [GRID_W-1:0] grid_rows;
    logic [ELEV_W-1:0] nodata_value;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic [STEP_W-1:0] step_diag;
  } cfg_t;

  typedef struct packed {
    logic busy;
  } back_status_t;

endpackage

[design/cri_front.sv]
// ----------------------------------------------------------------------------
// cri_front: input side of the interpolator
// Takes transactions and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module cri_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cri_pkg::in_item_t in_data_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output cri_pkg::in_item_t q_item_o
);

  localparam int PW = (cri_pkg::QUEUE_DEPTH > 1) ? $clog2(cri_pkg::QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(cri_pkg::QUEUE_DEPTH + 1);

  cri_pkg::in_item_t slot_q [cri_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]   cnt_q;
  logic              push, pop;

  assign in_ready_o = (cnt_q != CNTW'(cri_pkg::QUEUE_DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(cri_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

endmodule

[design/cri_div.sv]
// ----------------------------------------------------------------------------
// cri_div: unsigned restoring divider
// One quotient bit per cycle; done pulses for one cycle with the results.
// ----------------------------------------------------------------------------
module cri_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial  = {rem_q, quo_q[NUM_W-1]};
  assign fits   = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

[design/cri_back.sv]
// ----------------------------------------------------------------------------
// cri_back: raster store and interpolation sequencer
// Executes loads and reads, walks the four lines, picks the steepest one.
// ----------------------------------------------------------------------------
module cri_back #(
  parameter int MAX_COLUMNS = cri_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = cri_pkg::DEF_MAX_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cri_pkg::cfg_t         cfg_i,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  cri_pkg::in_item_t     q_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cri_pkg::out_item_t    out_data_o,
  output cri_pkg::back_status_t status_o
);

  localparam int EW   = cri_pkg::ELEV_W;
  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW   = $clog2(CELLS);
  localparam int DMAX = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
  localparam int NTW  = $clog2(2 * DMAX);
  localparam int DW   = EW + 1;
  localparam int DSW  = NTW + cri_pkg::STEP_W;
  localparam int PW   = DW + DSW;
  localparam int NUMW = DW + NTW;
  localparam int TW   = NUMW + 2;
  localparam int MCW  = $clog2(DSW + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POS   = 4'd1;
  localparam logic [3:0] S_HCHK  = 4'd2;
  localparam logic [3:0] S_WSTEP = 4'd3;
  localparam logic [3:0] S_WCHK  = 4'd4;
  localparam logic [3:0] S_WEND  = 4'd5;
  localparam logic [3:0] S_LINE  = 4'd6;
  localparam logic [3:0] S_PREP  = 4'd7;
  localparam logic [3:0] S_MUL1  = 4'd8;
  localparam logic [3:0] S_MUL2  = 4'd9;
  localparam logic [3:0] S_NUM   = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  // raster store
  logic [EW-1:0] mem [CELLS];
  logic [EW-1:0] rdata_q;
  logic [AW-1:0] raddr, waddr;
  logic          we;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= q_item_i.elevation;
    end
    rdata_q <= mem[raddr];
  end

  // effective grid size
  logic [NTW-1:0] cols, rows;
  logic [AW:0]    cells;

  always_comb begin
    if (cfg_i.grid_columns == '0) begin
      cols = NTW'(1);
    end else if (int'(cfg_i.grid_columns) > MAX_COLUMNS) begin
      cols = NTW'(MAX_COLUMNS);
    end else begin
      cols = NTW'(cfg_i.grid_columns);
    end
    if (cfg_i.grid_rows == '0) begin
      rows = NTW'(1);
    end else if (int'(cfg_i.grid_rows) > MAX_ROWS) begin
      rows = NTW'(MAX_ROWS);
    end else begin
      rows = NTW'(cfg_i.grid_rows);
    end
  end

  assign cells = (AW+1)'(cols) * (AW+1)'(rows);

  // sequencer state
  logic [3:0]            state_q, state_d;
  logic [AW:0]           load_ptr_q, load_ptr_d;
  logic [AW-1:0]         rd_ptr_q, rd_ptr_d;
  logic                  phase_q, phase_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [NTW-1:0]        cc_q, cc_d, cr_q, cr_d;
  logic [NTW-1:0]        wc_q, wc_d, wr_q, wr_d;
  logic [AW-1:0]         wa_q, wa_d;
  logic [NTW-1:0]        n_q, n_d, n1_q, n1_d, n2_q, n2_d;
  logic [EW-1:0]         wv_q, wv_d, v1_q, v1_d, v2_q, v2_d;
  logic                  neg_q, neg_d, have_q, have_d;
  logic [1:0]            line_q, line_d;
  logic [DW-1:0]         best_abs_q, best_abs_d;
  logic [DSW-1:0]        best_dist_q, best_dist_d, dist_q, dist_d;
  logic [EW-1:0]         best_val_q, best_val_d;
  logic signed [DW-1:0]  diff_q, diff_d;
  logic [NTW-1:0]        ntot_q, ntot_d;
  logic [PW-1:0]         p_q, p_d, prod1_q, prod1_d;
  logic [DW-1:0]         ma_q, ma_d;
  logic [MCW-1:0]        mcnt_q, mcnt_d;
  logic                  num_neg_q, num_neg_d;
  logic                  out_valid_q, out_valid_d;
  cri_pkg::out_item_t    out_q, out_d;

  // shared divider
  logic             div_start, div_done;
  logic [NUMW-1:0]  div_num, div_quo;
  logic [NTW-1:0]   div_den, div_rem;

  cri_div #(
    .NUM_W (NUMW),
    .DEN_W (NTW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // walk direction of the current line and sense
  logic xp, xn, yp, yn, oob;
  logic [NTW-1:0] nc, nr;
  logic [AW-1:0]  na, cols_a;

  always_comb begin
    logic dx, dyp, dyn;
    dx  = (line_q != 2'd1);
    dyp = (line_q == 2'd1) || (line_q == 2'd2);
    dyn = (line_q == 2'd3);
    xp  = dx && !neg_q;
    xn  = dx && neg_q;
    yp  = (dyp && !neg_q) || (dyn && neg_q);
    yn  = (dyp && neg_q) || (dyn && !neg_q);
    oob = (xp && (wc_q + NTW'(1)) == cols) || (xn && wc_q == '0) ||
          (yp && (wr_q + NTW'(1)) == rows) || (yn && wr_q == '0);
    cols_a = AW'(cols);
    nc = xp ? wc_q + NTW'(1) : (xn ? wc_q - NTW'(1) : wc_q);
    nr = yp ? wr_q + NTW'(1) : (yn ? wr_q - NTW'(1) : wr_q);
    na = wa_q;
    if (yp) begin
      na = na + cols_a;
    end else if (yn) begin
      na = na - cols_a;
    end
    if (xp) begin
      na = na + AW'(1);
    end else if (xn) begin
      na = na - AW'(1);
    end
  end

  // serial multiplier step and helpers
  logic [DW:0]           mul_sum;
  logic [PW-1:0]         p_next;
  logic [DW-1:0]         adiff;
  logic [cri_pkg::STEP_W-1:0] step_sel;
  logic signed [DW+NTW:0] num_full;
  logic [NUMW:0]         q_s;
  logic signed [TW-1:0]  t_val;

  assign mul_sum = {1'b0, p_q[PW-1:DSW]} + (p_q[0] ? {1'b0, ma_q} : '0);
  assign p_next  = {mul_sum, p_q[DSW-1:1]};
  assign adiff   = diff_q[DW-1] ? DW'(-diff_q) : DW'(diff_q);
  assign step_sel = (line_q == 2'd0) ? cfg_i.step_x :
                    ((line_q == 2'd1) ? cfg_i.step_y : cfg_i.step_diag);
  assign num_full = diff_q * $signed({1'b0, n2_q});

  always_comb begin
    q_s   = num_neg_q ? (NUMW+1)'(-{1'b0, div_quo}) : {1'b0, div_quo};
    t_val = TW'($signed(v2_q)) + TW'($signed(q_s));
    if (div_rem != '0) begin
      if (!num_neg_q && t_val < 0) begin
        t_val = t_val + TW'(1);
      end else if (num_neg_q && t_val > 0) begin
        t_val = t_val - TW'(1);
      end
    end
  end

  assign q_ready_o = (state_q == S_IDLE) &&
                     ((q_item_i.operation == cri_pkg::OP_LOAD) || !out_valid_q);

  always_comb begin
    logic          next_line;
    logic [AW:0]   lp;
    state_d     = state_q;
    load_ptr_d  = load_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    cc_d        = cc_q;
    cr_d        = cr_q;
    wc_d        = wc_q;
    wr_d        = wr_q;
    wa_d        = wa_q;
    n_d         = n_q;
    n1_d        = n1_q;
    n2_d        = n2_q;
    wv_d        = wv_q;
    v1_d        = v1_q;
    v2_d        = v2_q;
    neg_d       = neg_q;
    have_d      = have_q;
    line_d      = line_q;
    best_abs_d  = best_abs_q;
    best_dist_d = best_dist_q;
    best_val_d  = best_val_q;
    diff_d      = diff_q;
    ntot_d      = ntot_q;
    dist_d      = dist_q;
    p_d         = p_q;
    prod1_d     = prod1_q;
    ma_d        = ma_q;
    mcnt_d      = mcnt_q;
    num_neg_d   = num_neg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = '0;
    raddr       = na;
    div_start   = 1'b0;
    div_num     = NUMW'(idx_d);
    div_den     = cols;
    next_line   = 1'b0;
    lp          = '0;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && q_ready_o) begin
          if (q_item_i.operation == cri_pkg::OP_LOAD) begin
            lp = phase_q ? '0 : load_ptr_q;
            if (phase_q) begin
              rd_ptr_d = '0;
            end
            phase_d = 1'b0;
            if (lp < cells) begin
              we         = 1'b1;
              waddr      = lp[AW-1:0];
              load_ptr_d = lp + (AW+1)'(1);
            end else begin
              load_ptr_d = lp;
            end
          end else begin
            phase_d   = 1'b1;
            idx_d     = ({1'b0, rd_ptr_q} >= cells) ? '0 : rd_ptr_q;
            div_start = 1'b1;
            div_num   = NUMW'(idx_d);
            div_den   = cols;
            state_d   = S_POS;
          end
        end
      end
      S_POS: begin
        raddr = idx_q;
        if (div_done) begin
          cc_d    = div_rem;
          cr_d    = NTW'(div_quo);
          state_d = S_HCHK;
        end
      end
      S_HCHK: begin
        best_val_d = rdata_q;
        if (rdata_q != cfg_i.nodata_value) begin
          state_d = S_OUT;
        end else begin
          best_val_d = cfg_i.nodata_value;
          have_d  = 1'b0;
          line_d  = 2'd0;
          neg_d   = 1'b0;
          wc_d    = cc_q;
          wr_d    = cr_q;
          wa_d    = idx_q;
          n_d     = '0;
          state_d = S_WSTEP;
        end
      end
      S_WSTEP: begin
        if (oob) begin
          n_d     = '0;
          state_d = S_WEND;
        end else begin
          wc_d    = nc;
          wr_d    = nr;
          wa_d    = na;
          n_d     = n_q + NTW'(1);
          state_d = S_WCHK;
        end
      end
      S_WCHK: begin
        if (rdata_q != cfg_i.nodata_value) begin
          wv_d    = rdata_q;
          state_d = S_WEND;
        end else begin
          state_d = S_WSTEP;
        end
      end
      S_WEND: begin
        wc_d = cc_q;
        wr_d = cr_q;
        wa_d = idx_q;
        n_d  = '0;
        if (!neg_q) begin
          n1_d    = n_q;
          v1_d    = wv_q;
          neg_d   = 1'b1;
          state_d = S_WSTEP;
        end else begin
          n2_d    = n_q;
          v2_d    = wv_q;
          state_d = S_LINE;
        end
      end
      S_LINE: begin
        if (n1_q == '0 || n2_q == '0 || step_sel == '0) begin
          next_line = 1'b1;
        end else begin
          diff_d  = DW'($signed(v1_q)) - DW'($signed(v2_q));
          ntot_d  = n1_q + n2_q;
          dist_d  = DSW'(n1_q + n2_q) * DSW'(step_sel);
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (!have_q) begin
          state_d = S_NUM;
        end else begin
          ma_d    = adiff;
          p_d     = PW'(best_dist_q);
          mcnt_d  = MCW'(DSW);
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        p_d    = p_next;
        mcnt_d = mcnt_q - MCW'(1);
        if (mcnt_q == MCW'(1)) begin
          prod1_d = p_next;
          ma_d    = best_abs_q;
          p_d     = PW'(dist_q);
          mcnt_d  = MCW'(DSW);
          state_d = S_MUL2;
        end
      end
      S_MUL2: begin
        p_d    = p_next;
        mcnt_d = mcnt_q - MCW'(1);
        if (mcnt_q == MCW'(1)) begin
          if (prod1_q > p_next) begin
            state_d = S_NUM;
          end else begin
            next_line = 1'b1;
          end
        end
      end
      S_NUM: begin
        num_neg_d = num_full[DW+NTW];
        div_start = 1'b1;
        div_num   = num_full[DW+NTW] ? NUMW'(-num_full) : NUMW'(num_full);
        div_den   = ntot_q;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          best_val_d  = t_val[EW-1:0];
          best_abs_d  = adiff;
          best_dist_d = dist_q;
          have_d      = 1'b1;
          next_line   = 1'b1;
        end
      end
      S_OUT: begin
        out_valid_d         = 1'b1;
        out_d.surface_value = best_val_q;
        out_d.cell_index    = cri_pkg::IDX_W'(idx_q);
        out_d.last_cell     = ({1'b0, idx_q} + (AW+1)'(1)) == cells;
        if (out_d.last_cell) begin
          rd_ptr_d   = '0;
          load_ptr_d = '0;
          phase_d    = 1'b0;
        end else begin
          rd_ptr_d = idx_q + AW'(1);
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (next_line) begin
      if (line_q == 2'd3) begin
        state_d = S_OUT;
      end else begin
        line_d  = line_q + 2'd1;
        neg_d   = 1'b0;
        wc_d    = cc_q;
        wr_d    = cr_q;
        wa_d    = idx_q;
        n_d     = '0;
        state_d = S_WSTEP;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    cc_q        <= cc_d;
    cr_q        <= cr_d;
    wc_q        <= wc_d;
    wr_q        <= wr_d;
    wa_q        <= wa_d;
    n_q         <= n_d;
    n1_q        <= n1_d;
    n2_q        <= n2_d;
    wv_q        <= wv_d;
    v1_q        <= v1_d;
    v2_q        <= v2_d;
    neg_q       <= neg_d;
    have_q      <= have_d;
    line_q      <= line_d;
    best_abs_q  <= best_abs_d;
    best_dist_q <= best_dist_d;
    best_val_q  <= best_val_d;
    diff_q      <= diff_d;
    ntot_q      <= ntot_d;
    dist_q      <= dist_d;
    p_q         <= p_d;
    prod1_q     <= prod1_d;
    ma_q        <= ma_d;
    mcnt_q      <= mcnt_d;
    num_neg_q   <= num_neg_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_ptr_q  <= '0;
      rd_ptr_q    <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_ptr_q  <= load_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign status_o.busy   = (state_q != S_IDLE);

endmodule

[design/contour_raster_interpolator.sv]
// ----------------------------------------------------------------------------
// contour_raster_interpolator: fills unknown raster cells from contour data
// Loads a raster in raster order, then returns every cell; unknown cells
// are linearly interpolated along the steepest of four lines, else no-data.
// ----------------------------------------------------------------------------
//
//  channel   signals                          notes
//  -------   ------------------------------   ---------------------------------
//  in        in_valid_i / in_ready_o / data   load or read transaction
//  out       out_valid_o / out_ready_i / data one result per read transaction
//  cfg       cfg_we_i / cfg_idx_i / data      register write, no wait
//
//  Loads retire once at the head of the two-entry queue, with the back end idle.
//  Every read takes its cell position from the shared serial divider of
//  NUMW bits (NUMW = 33 + clog2(2*max(MAX_COLUMNS,MAX_ROWS))). An unknown
//  cell adds walked steps, one store read each, over eight walks, plus a
//  serial slope compare on each later line with both ends and a division
//  on each line that takes the lead. No clearing pass after reset.
//  The queue keeps taking transactions, until its two entries are full, while
//  the back end works or while a result waits in the output register.
//
module contour_raster_interpolator #(
  parameter int MAX_COLUMNS = cri_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = cri_pkg::DEF_MAX_ROWS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  cri_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output cri_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [cri_pkg::CFG_ADDR_W-1:0]    cfg_idx_i,
  input  logic [cri_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // configuration registers
  cri_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_columns <= cri_pkg::RST_GRID;
      cfg_q.grid_rows    <= cri_pkg::RST_GRID;
      cfg_q.nodata_value <= cri_pkg::RST_NODATA;
      cfg_q.step_x       <= cri_pkg::RST_STEP_AXIS;
      cfg_q.step_y       <= cri_pkg::RST_STEP_AXIS;
      cfg_q.step_diag    <= cri_pkg::RST_STEP_DIAG;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cri_pkg::REG_GRID_COLUMNS: cfg_q.grid_columns <= cfg_data_i[cri_pkg::GRID_W-1:0];
        cri_pkg::REG_GRID_ROWS:    cfg_q.grid_rows    <= cfg_data_i[cri_pkg::GRID_W-1:0];
        cri_pkg::REG_NODATA_VALUE: cfg_q.nodata_value <= cfg_data_i[cri_pkg::ELEV_W-1:0];
        cri_pkg::REG_STEP_X:       cfg_q.step_x       <= cfg_data_i[cri_pkg::STEP_W-1:0];
        cri_pkg::REG_STEP_Y:       cfg_q.step_y       <= cfg_data_i[cri_pkg::STEP_W-1:0];
        cri_pkg::REG_STEP_DIAG:    cfg_q.step_diag    <= cfg_data_i[cri_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // front: queue of accepted transactions
  logic                  q_valid, q_ready;
  cri_pkg::in_item_t     q_item;
  cri_pkg::back_status_t st;

  cri_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  // back: store, line walks, slope compare, interpolation
  cri_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .status_o    (st)
  );

  // back end only pops while idle
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready) |-> !st.busy)
    else $error("queue popped while back end busy");

  // a result is never shown twice
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> !out_valid_o)
    else $error("result repeated after transaction");

  // results only come out of a running read
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(st.busy))
    else $error("result without work");

endmodule

[sim/contour_raster_interpolator_test.sv]
// ----------------------------------------------------------------------------
// contour_raster_interpolator_test: self-checking bench of the interpolator
// Loads rasters of many sizes and register settings, reads them back and
// checks every returned cell against an in-bench predictor of the fill rule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module contour_raster_interpolator_test;

  localparam int STORE_CELLS = cri_pkg::DEF_MAX_COLUMNS * cri_pkg::DEF_MAX_ROWS;
  localparam longint CYCLE_LIMIT = 40_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  cri_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  cri_pkg::out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [cri_pkg::CFG_ADDR_W-1:0] cfg_idx_i = '0;
  logic [cri_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  contour_raster_interpolator dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: raster, pointers, phase and the register file.
  logic [31:0] raster_copy [STORE_CELLS];
  int unsigned load_ptr, read_ptr;
  bit          reading;
  logic [6:0]  cfg_cols, cfg_rows;
  logic [31:0] cfg_nodata;
  logic [23:0] cfg_step_x, cfg_step_y, cfg_step_diag;

  cri_pkg::in_item_t  pending_items [$];
  cri_pkg::out_item_t expected_cells [$];
  int  send_idle_pct, recv_idle_pct;
  bit  failed;
  longint cycles;

  function automatic int eff_dim(logic [6:0] v);
    if (v == 0) return 1;
    return (v > 64) ? 64 : int'(v);
  endfunction

  function automatic longint sext(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // Steps to the nearest known cell along (dc,dr); 0 when the grid is left.
  function automatic int steps_to_known(int c, int r, int dc, int dr, int cols, int rows,
                                        output longint val);
    int n;
    n = 0;
    val = 0;
    forever begin
      c += dc;
      r += dr;
      n++;
      if (c < 0 || c >= cols || r < 0 || r >= rows) return 0;
      if (raster_copy[r * cols + c] != cfg_nodata) begin
        val = sext(raster_copy[r * cols + c]);
        return n;
      end
    end
  endfunction

  function automatic logic [31:0] surface_at(int idx, int cols, int rows);
    longint v1, v2, diff, num, q, rem, t, best_val;
    longint unsigned adiff, line_dist, best_abs, best_dist;
    logic [127:0] lhs, rhs;
    logic [23:0] stp;
    int c, r, n1, n2, dc, dr;
    bit have, better;
    if (raster_copy[idx] != cfg_nodata) return raster_copy[idx];
    c = idx % cols;
    r = idx / cols;
    have = 0;
    best_abs = 0;
    best_dist = 1;
    best_val = sext(cfg_nodata);
    for (int d = 0; d < 4; d++) begin
      case (d)
        0: begin dc = 1; dr = 0;  stp = cfg_step_x; end
        1: begin dc = 0; dr = 1;  stp = cfg_step_y; end
        2: begin dc = 1; dr = 1;  stp = cfg_step_diag; end
        default: begin dc = 1; dr = -1; stp = cfg_step_diag; end
      endcase
      n1 = steps_to_known(c, r, dc, dr, cols, rows, v1);
      n2 = steps_to_known(c, r, -dc, -dr, cols, rows, v2);
      if (n1 == 0 || n2 == 0 || stp == 0) continue;
      diff = v1 - v2;
      adiff = (diff < 0) ? longint'(-diff) : longint'(diff);
      line_dist = longint'(n1 + n2) * longint'(stp);
      // exact slope comparison by cross multiplication
      lhs = 128'(adiff) * 128'(best_dist);
      rhs = 128'(best_abs) * 128'(line_dist);
      better = !have || (lhs > rhs);
      if (!better) continue;
      num = diff * longint'(n2);
      q = num / longint'(n1 + n2);
      rem = num % longint'(n1 + n2);
      t = v2 + q;
      if (rem > 0 && t < 0) t += 1;
      else if (rem < 0 && t > 0) t -= 1;
      have = 1;
      best_abs = adiff;
      best_dist = line_dist;
      best_val = t;
    end
    return best_val[31:0];
  endfunction

  // Advances the predictor by one accepted transaction.
  task automatic predict(cri_pkg::in_item_t it);
    int cols, rows, cells;
    cri_pkg::out_item_t res;
    cols = eff_dim(cfg_cols);
    rows = eff_dim(cfg_rows);
    cells = cols * rows;
    if (it.operation == cri_pkg::OP_LOAD) begin
      if (reading) begin
        reading = 0;
        load_ptr = 0;
        read_ptr = 0;
      end
      if (load_ptr < cells) begin
        raster_copy[load_ptr] = it.elevation;
        load_ptr++;
      end
    end else begin
      reading = 1;
      if (read_ptr >= cells) read_ptr = 0;
      res.surface_value = surface_at(read_ptr, cols, rows);
      res.cell_index = read_ptr[cri_pkg::IDX_W-1:0];
      res.last_cell = (read_ptr + 1 == cells);
      expected_cells.push_back(res);
      if (res.last_cell) begin
        read_ptr = 0;
        load_ptr = 0;
        reading = 0;
      end else begin
        read_ptr++;
      end
    end
  endtask

  // Driver: presents queued transactions, idles at random between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compares each result with the oldest
  // expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_cells.size() == 0) begin
          $display("%0t: result expected none got %p", $time, out_data_o);
          failed = 1;
        end else begin
          cri_pkg::out_item_t exp_cell;
          exp_cell = expected_cells.pop_front();
          if (exp_cell.surface_value !== out_data_o.surface_value) begin
            $display("%0t: surface_value expected %0d got %0d", $time,
                     exp_cell.surface_value, out_data_o.surface_value);
            failed = 1;
          end
          if (exp_cell.cell_index !== out_data_o.cell_index) begin
            $display("%0t: cell_index expected %0d got %0d", $time,
                     exp_cell.cell_index, out_data_o.cell_index);
            failed = 1;
          end
          if (exp_cell.last_cell !== out_data_o.last_cell) begin
            $display("%0t: last_cell expected %0b got %0b", $time,
                     exp_cell.last_cell, out_data_o.last_cell);
            failed = 1;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("contour_raster_interpolator regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [cri_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      cri_pkg::REG_GRID_COLUMNS: cfg_cols = val[6:0];
      cri_pkg::REG_GRID_ROWS:    cfg_rows = val[6:0];
      cri_pkg::REG_NODATA_VALUE: cfg_nodata = val;
      cri_pkg::REG_STEP_X:       cfg_step_x = val[23:0];
      cri_pkg::REG_STEP_Y:       cfg_step_y = val[23:0];
      cri_pkg::REG_STEP_DIAG:    cfg_step_diag = val[23:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Everything sent, every result back, then a wait for trailing loads.
  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid_i && expected_cells.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_elev();
    case ($urandom_range(9))
      0, 1, 2, 3: return cfg_nodata;                      // unknown cell
      4:          return $urandom();
      5:          return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default:    return 32'($signed($urandom_range(20000)) - 10000);
    endcase
  endfunction

  function automatic logic [23:0] rand_step();
    case ($urandom_range(7))
      0:       return 24'd0;                              // drops the line
      1:       return 24'hFF_FFFF;
      2:       return 24'($urandom());
      default: return 24'($urandom_range(1, 1024));
    endcase
  endfunction

  task automatic push(cri_pkg::op_e op, logic [31:0] val);
    cri_pkg::in_item_t it;
    it.operation = op;
    it.elevation = val;
    pending_items.push_back(it);
  endtask

  // Queues a full load of the current grid, optional overrun loads, then
  // nreads reads.
  task automatic queue_frame(int extra_loads, int nreads);
    int cells;
    cells = eff_dim(cfg_cols) * eff_dim(cfg_rows);
    for (int i = 0; i < cells + extra_loads; i++) push(cri_pkg::OP_LOAD, rand_elev());
    for (int i = 0; i < nreads; i++) push(cri_pkg::OP_READ, $urandom());
  endtask

  initial begin
    int cells, n_items, mode;
    failed = 0;
    cycles = 0;
    send_idle_pct = 26;
    recv_idle_pct = 51;
    reading = 0;
    load_ptr = 0;
    read_ptr = 0;
    cfg_cols = cri_pkg::RST_GRID;
    cfg_rows = cri_pkg::RST_GRID;
    cfg_nodata = cri_pkg::RST_NODATA;
    cfg_step_x = cri_pkg::RST_STEP_AXIS;
    cfg_step_y = cri_pkg::RST_STEP_AXIS;
    cfg_step_diag = cri_pkg::RST_STEP_DIAG;
    foreach (raster_copy[i]) raster_copy[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 3x3 with a hole in the middle (three lines usable) and one in a corner, extremes.
    write_reg(cri_pkg::REG_GRID_COLUMNS, 3);
    write_reg(cri_pkg::REG_GRID_ROWS, 3);
    push(cri_pkg::OP_LOAD, 32'h8000_0000);
    push(cri_pkg::OP_LOAD, 32'd256);
    push(cri_pkg::OP_LOAD, 32'h7FFF_FFFF);
    push(cri_pkg::OP_LOAD, -32'sd512);
    push(cri_pkg::OP_LOAD, cri_pkg::RST_NODATA);
    push(cri_pkg::OP_LOAD, 32'd1000);
    push(cri_pkg::OP_LOAD, 32'd7);
    push(cri_pkg::OP_LOAD, -32'sd3);
    push(cri_pkg::OP_LOAD, cri_pkg::RST_NODATA);
    push(cri_pkg::OP_LOAD, 32'd99);        // past the grid, ignored
    for (int i = 0; i < 9; i++) push(cri_pkg::OP_READ, 32'hFFFF_FFFF);
    drain();

    // Zero grid registers act as one cell: lone unknown cell gives no-data.
    write_reg(cri_pkg::REG_GRID_COLUMNS, 0);
    write_reg(cri_pkg::REG_GRID_ROWS, 0);
    push(cri_pkg::OP_LOAD, cri_pkg::RST_NODATA);
    push(cri_pkg::OP_READ, 0);
    drain();

    // Saturated columns (64 x 2) with zero spacings, then 2 x 64.
    write_reg(cri_pkg::REG_GRID_COLUMNS, 127);
    write_reg(cri_pkg::REG_GRID_ROWS, 2);
    write_reg(cri_pkg::REG_STEP_X, 0);
    write_reg(cri_pkg::REG_STEP_Y, 24'hFF_FFFF);
    write_reg(cri_pkg::REG_STEP_DIAG, 0);
    queue_frame(0, 5);
    push(cri_pkg::OP_LOAD, 32'd5);         // load after reads restarts the frame
    drain();
    write_reg(cri_pkg::REG_GRID_COLUMNS, 2);
    write_reg(cri_pkg::REG_GRID_ROWS, 127);
    write_reg(cri_pkg::REG_STEP_X, 1);
    write_reg(cri_pkg::REG_STEP_DIAG, 24'hFF_FFFF);
    write_reg(cri_pkg::REG_NODATA_VALUE, 32'h7FFF_FFFF);
    queue_frame(0, 100);
    drain();
    // Shrink the grid below the read position: reads restart at cell 0.
    write_reg(cri_pkg::REG_GRID_ROWS, 3);
    for (int i = 0; i < 6; i++) push(cri_pkg::OP_READ, 0);
    drain();

    // Random frames under the three idling regimes.
    n_items = 0;
    mode = 0;
    while (n_items < 600) begin
      if (n_items >= 200 * (mode + 1) && mode < 2) begin
        mode++;
        send_idle_pct = (mode == 1) ? 51 : 0;
        recv_idle_pct = (mode == 1) ? 26 : 0;
      end
      write_reg(cri_pkg::REG_GRID_COLUMNS,
                ($urandom_range(19) == 0) ? $urandom_range(127) : $urandom_range(1, 8));
      write_reg(cri_pkg::REG_GRID_ROWS,
                ($urandom_range(19) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 8));
      if ($urandom_range(3) == 0)
        write_reg(cri_pkg::REG_NODATA_VALUE,
                  $urandom_range(1) ? $urandom() : 32'($signed($urandom_range(20)) - 10));
      write_reg(cri_pkg::REG_STEP_X, rand_step());
      write_reg(cri_pkg::REG_STEP_Y, rand_step());
      write_reg(cri_pkg::REG_STEP_DIAG, rand_step());
      cells = eff_dim(cfg_cols) * eff_dim(cfg_rows);
      case ($urandom_range(5))
        0: queue_frame($urandom_range(1, 3), cells);          // overrun loads
        1: queue_frame(0, $urandom_range(1, cells));          // cut short by next load
        default: queue_frame(0, cells);
      endcase
      n_items += pending_items.size();
      drain();
    end

    if (!failed) begin
      $display("contour_raster_interpolator regression: pass");
    end else begin
      $display("contour_raster_interpolator regression: fail");
    end
    $finish;
  end

endmodule
